FILE: rtl/chi_pkg.sv
package chi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SW  = FRAC_BITS + 1;
    localparam int SQW = 2 * FRAC_BITS + 2;
    localparam int CW  = FRAC_BITS + 4;
    localparam int QB  = FRAC_BITS + 35;
    localparam int VW  = FRAC_BITS + 70;
    localparam int PW  = FRAC_BITS + 38;

    localparam logic [SW-1:0] S_ONE   = SW'(1) << FRAC_BITS;
    localparam logic [VW-1:0] V_HALF  = VW'(1) << (FRAC_BITS - 1);
    localparam logic [PW-1:0] P_HALF  = PW'(1) << (FRAC_BITS - 1);
    localparam logic [31:0]   SAT_POS = 32'h7fff_ffff;
    localparam logic [31:0]   SAT_NEG = 32'h8000_0000;

    typedef logic signed [CW-1:0] t_coef;

    typedef struct packed {
        logic [31:0]        query_time;
        logic [31:0]        start_time;
        logic [31:0]        end_time;
        logic signed [31:0] start_value;
        logic signed [31:0] start_slope;
        logic signed [31:0] end_value;
        logic signed [31:0] end_slope;
        logic               last_component;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic signed [31:0] slope_out;
        logic               bad_interval;
        logic               saturated;
        logic               last_out;
    } t_out_word;

    typedef struct packed {
        logic valid;
        logic bad;
        logic last;
    } t_side;

    typedef struct packed {
        t_side              side;
        logic [31:0]        h;
        logic [SW-1:0]      s;
        logic signed [31:0] ya;
        logic signed [31:0] dya;
        logic signed [31:0] yb;
        logic signed [31:0] dyb;
    } t_div_word;

    typedef struct packed {
        t_side              side;
        logic [31:0]        h;
        logic               aneg;
        logic [QB-1:0]      amag;
        logic signed [VW-1:0] vsum;
        logic signed [PW-1:0] pd;
    } t_bas_word;

    typedef struct packed {
        t_side              side;
        logic               aneg;
        logic [QB-1:0]      quo;
        logic               rem_nz;
        logic signed [VW-1:0] vsum;
        logic signed [PW-1:0] pd;
    } t_qd_word;

endpackage

FILE: rtl/cubic_hermite_interpolator_core.sv
// Pipeline: FRAC_BITS + 1 position divider stages, 6 basis stages,
// FRAC_BITS + 35 slope divider stages, 3 output stages; the two restoring
// dividers retire one bit per stage.
// Throughput: one word per cycle while the output is not stalled.
// Reset: synchronous active-low i_rst_n clears every stage valid bit.
module cubic_hermite_interpolator_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  chi_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output chi_pkg::t_out_word o_data
);

    logic               en;
    chi_pkg::t_div_word div_word;
    chi_pkg::t_bas_word bas_word;
    chi_pkg::t_qd_word  qd_word;

    assign en      = ~o_valid | i_ready;
    assign o_ready = en;

    chi_sdiv u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_word  (div_word)
    );

    chi_basis u_basis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_word  (div_word),
        .o_word  (bas_word)
    );

    chi_qdiv u_qdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_word  (bas_word),
        .o_word  (qd_word)
    );

    chi_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_word  (qd_word),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

FILE: rtl/chi_sdiv.sv
module chi_sdiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  chi_pkg::t_in_word  i_data,
    output chi_pkg::t_div_word o_word
);

    typedef struct packed {
        logic                           valid;
        logic                           bad;
        logic                           last;
        logic                           lo;
        logic                           hi;
        logic [31:0]                    h;
        logic [31:0]                    rem;
        logic [chi_pkg::FRAC_BITS-1:0]  quo;
        logic signed [31:0]             ya;
        logic signed [31:0]             dya;
        logic signed [31:0]             yb;
        logic signed [31:0]             dyb;
    } t_sd_stage;

    t_sd_stage r_st [chi_pkg::FRAC_BITS+1];
    t_sd_stage n_st [chi_pkg::FRAC_BITS+1];

    function automatic t_sd_stage f_step(input t_sd_stage x);
        t_sd_stage   y;
        logic [32:0] rem2;
        logic        ge;
        y    = x;
        rem2 = {x.rem, 1'b0};
        ge   = rem2 >= {1'b0, x.h};
        y.rem = ge ? 32'(rem2 - {1'b0, x.h}) : rem2[31:0];
        y.quo = {x.quo[chi_pkg::FRAC_BITS-2:0], ge};
        return y;
    endfunction

    always_comb begin
        n_st[0].valid = i_valid;
        n_st[0].bad   = i_data.end_time <= i_data.start_time;
        n_st[0].last  = i_data.last_component;
        n_st[0].lo    = i_data.query_time <= i_data.start_time;
        n_st[0].hi    = i_data.query_time >= i_data.end_time;
        n_st[0].h     = i_data.end_time - i_data.start_time;
        n_st[0].rem   = i_data.query_time - i_data.start_time;
        n_st[0].quo   = '0;
        n_st[0].ya    = i_data.start_value;
        n_st[0].dya   = i_data.start_slope;
        n_st[0].yb    = i_data.end_value;
        n_st[0].dyb   = i_data.end_slope;
        for (int k = 1; k <= chi_pkg::FRAC_BITS; k++) begin
            n_st[k] = f_step(r_st[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= chi_pkg::FRAC_BITS; k++) begin
                r_st[k].valid <= 1'b0;
            end
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    always_comb begin
        o_word.side.valid = r_st[chi_pkg::FRAC_BITS].valid;
        o_word.side.bad   = r_st[chi_pkg::FRAC_BITS].bad;
        o_word.side.last  = r_st[chi_pkg::FRAC_BITS].last;
        o_word.h          = r_st[chi_pkg::FRAC_BITS].h;
        o_word.ya         = r_st[chi_pkg::FRAC_BITS].ya;
        o_word.dya        = r_st[chi_pkg::FRAC_BITS].dya;
        o_word.yb         = r_st[chi_pkg::FRAC_BITS].yb;
        o_word.dyb        = r_st[chi_pkg::FRAC_BITS].dyb;
        if (r_st[chi_pkg::FRAC_BITS].lo) begin
            o_word.s = '0;
        end else if (r_st[chi_pkg::FRAC_BITS].hi) begin
            o_word.s = chi_pkg::S_ONE;
        end else begin
            o_word.s = chi_pkg::SW'(r_st[chi_pkg::FRAC_BITS].quo);
        end
    end

    a_rem_below_h: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st[chi_pkg::FRAC_BITS].valid && !r_st[chi_pkg::FRAC_BITS].bad &&
        !r_st[chi_pkg::FRAC_BITS].lo && !r_st[chi_pkg::FRAC_BITS].hi
        |-> r_st[chi_pkg::FRAC_BITS].rem < r_st[chi_pkg::FRAC_BITS].h)
        else $error("position divider remainder not below interval length");

endmodule

FILE: rtl/chi_basis.sv
module chi_basis (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  chi_pkg::t_div_word i_word,
    output chi_pkg::t_bas_word o_word
);

    chi_pkg::t_side r1_side, r2_side, r3_side, r4_side, r5_side, r6_side;

    logic [chi_pkg::SW-1:0]  r1_s, r1_s2;
    logic [31:0]             r1_h;
    logic signed [31:0]      r1_ya, r1_dya, r1_yb, r1_dyb;
    logic [chi_pkg::SQW-1:0] n1_sq;

    logic [chi_pkg::SW-1:0]  r2_s, r2_s2, r2_s3;
    logic [31:0]             r2_h;
    logic signed [31:0]      r2_ya, r2_dya, r2_yb, r2_dyb;
    logic signed [63:0]      r2_hdya, r2_hdyb;
    logic signed [32:0]      r2_dy;
    logic [chi_pkg::SQW-1:0] n2_cube;
    logic signed [64:0]      n2_hdya, n2_hdyb;

    chi_pkg::t_coef          es, es2, es3;
    chi_pkg::t_coef          n3_c00, n3_c10, n3_c01, n3_c11, n3_ca, n3_cd10, n3_cd11;
    chi_pkg::t_coef          r3_c00, r3_c10, r3_c01, r3_c11, r3_ca, r3_cd10, r3_cd11;
    logic [31:0]             r3_h;
    logic signed [31:0]      r3_ya, r3_dya, r3_yb, r3_dyb;
    logic signed [63:0]      r3_hdya, r3_hdyb;
    logic signed [32:0]      r3_dy;

    logic signed [chi_pkg::CW+31:0] r4_p00, r4_p01, r4_p10h, r4_p11h, r4_pd10, r4_pd11;
    logic signed [chi_pkg::CW+32:0] r4_p10l, r4_p11l, r4_pa;
    logic [31:0]                    r4_h;

    logic signed [chi_pkg::VW-1:0] r5_va, r5_vb;
    logic signed [chi_pkg::PW-1:0] r5_pd;
    logic [chi_pkg::QB-1:0]        r5_amag;
    logic                          r5_aneg;
    logic [31:0]                   r5_h;

    logic signed [chi_pkg::VW-1:0] r6_vsum;
    logic signed [chi_pkg::PW-1:0] r6_pd;
    logic [chi_pkg::QB-1:0]        r6_amag;
    logic                          r6_aneg;
    logic [31:0]                   r6_h;

    always_comb begin
        n1_sq   = chi_pkg::SQW'(i_word.s) * chi_pkg::SQW'(i_word.s);
        n2_cube = chi_pkg::SQW'(r1_s2) * chi_pkg::SQW'(r1_s);
        n2_hdya = 65'($signed({1'b0, r1_h})) * 65'(r1_dya);
        n2_hdyb = 65'($signed({1'b0, r1_h})) * 65'(r1_dyb);
        es      = $signed(chi_pkg::CW'(r2_s));
        es2     = $signed(chi_pkg::CW'(r2_s2));
        es3     = $signed(chi_pkg::CW'(r2_s3));
        n3_c00  = (es3 <<< 1) - ((es2 <<< 1) + es2) + $signed(chi_pkg::CW'(chi_pkg::S_ONE));
        n3_c10  = es3 - (es2 <<< 1) + es;
        n3_c01  = ((es2 <<< 1) + es2) - (es3 <<< 1);
        n3_c11  = es3 - es2;
        n3_ca   = (es2 <<< 2) + (es2 <<< 1) - (es <<< 2) - (es <<< 1);
        n3_cd10 = (es2 <<< 1) + es2 - (es <<< 2) + $signed(chi_pkg::CW'(chi_pkg::S_ONE));
        n3_cd11 = (es2 <<< 1) + es2 - (es <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side <= '0;
            r2_side <= '0;
            r3_side <= '0;
            r4_side <= '0;
            r5_side <= '0;
            r6_side <= '0;
        end else if (i_en) begin
            r1_side <= i_word.side;
            r2_side <= r1_side;
            r3_side <= r2_side;
            r4_side <= r3_side;
            r5_side <= r4_side;
            r6_side <= r5_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_s    <= i_word.s;
            r1_s2   <= n1_sq[2*chi_pkg::FRAC_BITS:chi_pkg::FRAC_BITS];
            r1_h    <= i_word.h;
            r1_ya   <= i_word.ya;
            r1_dya  <= i_word.dya;
            r1_yb   <= i_word.yb;
            r1_dyb  <= i_word.dyb;

            r2_s    <= r1_s;
            r2_s2   <= r1_s2;
            r2_s3   <= n2_cube[2*chi_pkg::FRAC_BITS:chi_pkg::FRAC_BITS];
            r2_h    <= r1_h;
            r2_ya   <= r1_ya;
            r2_dya  <= r1_dya;
            r2_yb   <= r1_yb;
            r2_dyb  <= r1_dyb;
            r2_hdya <= n2_hdya[63:0];
            r2_hdyb <= n2_hdyb[63:0];
            r2_dy   <= 33'(r1_ya) - 33'(r1_yb);

            r3_c00  <= n3_c00;
            r3_c10  <= n3_c10;
            r3_c01  <= n3_c01;
            r3_c11  <= n3_c11;
            r3_ca   <= n3_ca;
            r3_cd10 <= n3_cd10;
            r3_cd11 <= n3_cd11;
            r3_h    <= r2_h;
            r3_ya   <= r2_ya;
            r3_dya  <= r2_dya;
            r3_yb   <= r2_yb;
            r3_dyb  <= r2_dyb;
            r3_hdya <= r2_hdya;
            r3_hdyb <= r2_hdyb;
            r3_dy   <= r2_dy;

            r4_p00  <= (chi_pkg::CW+32)'(r3_c00) * (chi_pkg::CW+32)'(r3_ya);
            r4_p01  <= (chi_pkg::CW+32)'(r3_c01) * (chi_pkg::CW+32)'(r3_yb);
            r4_p10h <= (chi_pkg::CW+32)'(r3_c10) * (chi_pkg::CW+32)'($signed(r3_hdya[63:32]));
            r4_p11h <= (chi_pkg::CW+32)'(r3_c11) * (chi_pkg::CW+32)'($signed(r3_hdyb[63:32]));
            r4_p10l <= (chi_pkg::CW+33)'(r3_c10) *
                       (chi_pkg::CW+33)'($signed({1'b0, r3_hdya[31:0]}));
            r4_p11l <= (chi_pkg::CW+33)'(r3_c11) *
                       (chi_pkg::CW+33)'($signed({1'b0, r3_hdyb[31:0]}));
            r4_pa   <= (chi_pkg::CW+33)'(r3_ca) * (chi_pkg::CW+33)'(r3_dy);
            r4_pd10 <= (chi_pkg::CW+32)'(r3_cd10) * (chi_pkg::CW+32)'(r3_dya);
            r4_pd11 <= (chi_pkg::CW+32)'(r3_cd11) * (chi_pkg::CW+32)'(r3_dyb);
            r4_h    <= r3_h;

            r5_va   <= chi_pkg::VW'(r4_p00) + chi_pkg::VW'(r4_p01) +
                       chi_pkg::VW'(r4_p10l) + chi_pkg::VW'(r4_p11l);
            r5_vb   <= chi_pkg::VW'(r4_p10h) + chi_pkg::VW'(r4_p11h);
            r5_pd   <= chi_pkg::PW'(r4_pd10) + chi_pkg::PW'(r4_pd11);
            r5_aneg <= r4_pa[chi_pkg::CW+32];
            r5_amag <= r4_pa[chi_pkg::CW+32] ? chi_pkg::QB'(-r4_pa) : chi_pkg::QB'(r4_pa);
            r5_h    <= r4_h;

            r6_vsum <= (r5_vb <<< 32) + r5_va;
            r6_pd   <= r5_pd;
            r6_aneg <= r5_aneg;
            r6_amag <= r5_amag;
            r6_h    <= r5_h;
        end
    end

    always_comb begin
        o_word.side = r6_side;
        o_word.h    = r6_h;
        o_word.aneg = r6_aneg;
        o_word.amag = r6_amag;
        o_word.vsum = r6_vsum;
        o_word.pd   = r6_pd;
    end

endmodule

FILE: rtl/chi_qdiv.sv
module chi_qdiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  chi_pkg::t_bas_word i_word,
    output chi_pkg::t_qd_word  o_word
);

    typedef struct packed {
        chi_pkg::t_side                side;
        logic                          aneg;
        logic [31:0]                   h;
        logic [chi_pkg::QB-1:0]        num;
        logic [31:0]                   rem;
        logic signed [chi_pkg::VW-1:0] vsum;
        logic signed [chi_pkg::PW-1:0] pd;
    } t_qd_stage;

    t_qd_stage r_st [chi_pkg::QB];
    t_qd_stage n_st [chi_pkg::QB];
    t_qd_stage head;

    function automatic t_qd_stage f_step(input t_qd_stage x);
        t_qd_stage   y;
        logic [32:0] rem2;
        logic        ge;
        y    = x;
        rem2 = {x.rem, x.num[chi_pkg::QB-1]};
        ge   = rem2 >= {1'b0, x.h};
        y.rem = ge ? 32'(rem2 - {1'b0, x.h}) : rem2[31:0];
        y.num = {x.num[chi_pkg::QB-2:0], ge};
        return y;
    endfunction

    always_comb begin
        head.side = i_word.side;
        head.aneg = i_word.aneg;
        head.h    = i_word.h;
        head.num  = i_word.amag;
        head.rem  = '0;
        head.vsum = i_word.vsum;
        head.pd   = i_word.pd;
        n_st[0]   = f_step(head);
        for (int k = 1; k < chi_pkg::QB; k++) begin
            n_st[k] = f_step(r_st[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < chi_pkg::QB; k++) begin
                r_st[k].side <= '0;
            end
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    always_comb begin
        o_word.side   = r_st[chi_pkg::QB-1].side;
        o_word.aneg   = r_st[chi_pkg::QB-1].aneg;
        o_word.quo    = r_st[chi_pkg::QB-1].num;
        o_word.rem_nz = |r_st[chi_pkg::QB-1].rem;
        o_word.vsum   = r_st[chi_pkg::QB-1].vsum;
        o_word.pd     = r_st[chi_pkg::QB-1].pd;
    end

    a_rem_below_h: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st[chi_pkg::QB-1].side.valid && !r_st[chi_pkg::QB-1].side.bad
        |-> r_st[chi_pkg::QB-1].rem < r_st[chi_pkg::QB-1].h)
        else $error("slope divider remainder not below interval length");

endmodule

FILE: rtl/chi_out.sv
module chi_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  chi_pkg::t_qd_word  i_word,
    output logic               o_valid,
    output chi_pkg::t_out_word o_data
);

    chi_pkg::t_side                r1_side, r2_side;
    logic signed [chi_pkg::PW-1:0] n1_q, r1_q, r1_pd, r2_ssum;
    logic signed [chi_pkg::VW-1:0] r1_vsum, r2_vr;
    logic [32:0]                   n3_v, n3_s;
    logic                          r_valid;
    chi_pkg::t_out_word            r_out, n_out;

    function automatic logic [32:0] f_sat(input logic signed [chi_pkg::VW-1:0] x);
        logic signed [chi_pkg::VW-1:0] t;
        logic                          fits;
        t    = x >>> chi_pkg::FRAC_BITS;
        fits = (&t[chi_pkg::VW-1:31]) | ~(|t[chi_pkg::VW-1:31]);
        if (fits) begin
            return {1'b0, t[31:0]};
        end
        return {1'b1, t[chi_pkg::VW-1] ? chi_pkg::SAT_NEG : chi_pkg::SAT_POS};
    endfunction

    always_comb begin
        if (i_word.aneg) begin
            n1_q = -$signed(chi_pkg::PW'(i_word.quo)) - $signed(chi_pkg::PW'(i_word.rem_nz));
        end else begin
            n1_q = $signed(chi_pkg::PW'(i_word.quo));
        end
        n3_v = f_sat(r2_vr);
        n3_s = f_sat(chi_pkg::VW'(r2_ssum));
        n_out.last_out     = r2_side.last;
        n_out.bad_interval = r2_side.bad;
        if (r2_side.bad) begin
            n_out.value_out = '0;
            n_out.slope_out = '0;
            n_out.saturated = 1'b0;
        end else begin
            n_out.value_out = $signed(n3_v[31:0]);
            n_out.slope_out = $signed(n3_s[31:0]);
            n_out.saturated = n3_v[32] | n3_s[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side <= '0;
            r2_side <= '0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r1_side <= i_word.side;
            r2_side <= r1_side;
            r_valid <= r2_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_q    <= n1_q;
            r1_pd   <= i_word.pd;
            r1_vsum <= i_word.vsum;
            r2_ssum <= r1_q + r1_pd + $signed(chi_pkg::P_HALF);
            r2_vr   <= r1_vsum + $signed(chi_pkg::V_HALF);
            r_out   <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_out.bad_interval
        |-> r_out.value_out == 0 && r_out.slope_out == 0 && !r_out.saturated)
        else $error("empty interval word carries nonzero result");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

class hermite_scoreboard;
    chi_pkg::t_out_word pending[$];
    int errors;
    int shown;

    function automatic logic signed [31:0] clip(logic signed [127:0] acc, ref bit sat);
        logic signed [127:0] r;
        r = (acc + (128'sd1 <<< 15)) >>> 16;
        if (r > 128'sd2147483647) begin
            sat = 1;
            return 32'h7fff_ffff;
        end
        if (r < -128'sd2147483648) begin
            sat = 1;
            return 32'h8000_0000;
        end
        return r[31:0];
    endfunction

    function void note_input(chi_pkg::t_in_word w);
        chi_pkg::t_out_word e;
        logic signed [127:0] ya, dya, yb, dyb, h, s, s2, s3, val, slp, a, q;
        bit sat;
        e = '0;
        e.last_out = w.last_component;
        sat = 0;
        if (w.end_time <= w.start_time) begin
            e.bad_interval = 1;
        end else begin
            ya = w.start_value;
            dya = w.start_slope;
            yb = w.end_value;
            dyb = w.end_slope;
            h = {96'd0, w.end_time - w.start_time};
            if (w.query_time <= w.start_time) s = 0;
            else if (w.query_time >= w.end_time) s = 128'sd65536;
            else s = ({96'd0, w.query_time - w.start_time} <<< 16) / h;
            s2 = (s * s) >>> 16;
            s3 = (s2 * s) >>> 16;
            val = (2 * s3 - 3 * s2 + 65536) * ya + (s3 - 2 * s2 + s) * h * dya
                + (-2 * s3 + 3 * s2) * yb + (s3 - s2) * h * dyb;
            a = (6 * s2 - 6 * s) * (ya - yb);
            q = a / h;
            if (a < 0 && a % h != 0) q = q - 1;
            slp = q + (3 * s2 - 4 * s + 65536) * dya + (3 * s2 - 2 * s) * dyb;
            e.value_out = clip(val, sat);
            e.slope_out = clip(slp, sat);
            e.saturated = sat;
        end
        pending.push_back(e);
    endfunction

    function void check_result(chi_pkg::t_out_word got);
        chi_pkg::t_out_word e;
        if (pending.size() == 0) begin
            errors++;
            if (shown < 10) begin
                shown++;
                $display("unexpected word %h", got);
            end
            return;
        end
        e = pending.pop_front();
        if (got !== e) begin
            errors++;
            if (shown < 10) begin
                shown++;
                $display("mismatch exp v=%h s=%h b=%b sat=%b l=%b got v=%h s=%h b=%b sat=%b l=%b",
                    e.value_out, e.slope_out, e.bad_interval, e.saturated, e.last_out,
                    got.value_out, got.slope_out, got.bad_interval, got.saturated,
                    got.last_out);
            end
        end
    endfunction
endclass

module tb;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_ready;
    chi_pkg::t_in_word i_data = '0;
    logic o_valid;
    logic i_ready = 0;
    chi_pkg::t_out_word o_data;

    hermite_scoreboard board = new();
    bit stim_done = 0;
    int stall_mode = 0;

    cubic_hermite_interpolator_core u_top (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            4: return $urandom_range(0, 1000) - 500;
            default: return $urandom;
        endcase
    endfunction

    function automatic chi_pkg::t_in_word rand_word();
        chi_pkg::t_in_word w;
        logic [31:0] base, span;
        w.start_value = pick32();
        w.start_slope = $urandom_range(0, 3) == 0 ? pick32() : $urandom_range(0, 4000) - 2000;
        w.end_value = pick32();
        w.end_slope = $urandom_range(0, 3) == 0 ? pick32() : $urandom_range(0, 4000) - 2000;
        w.last_component = 1'($urandom_range(0, 1));
        base = $urandom;
        case ($urandom_range(0, 9))
            0: span = 0;
            1: span = -$urandom_range(1, 1000);
            2: span = $urandom;
            3: span = $urandom_range(1, 4);
            default: span = $urandom_range(1, 100000);
        endcase
        if ($urandom_range(0, 5) != 0 && span != 0 && span < 32'h8000_0000) begin
            if (base > 32'hffff_ffff - span) base = 32'hffff_ffff - span;
        end
        w.start_time = base;
        w.end_time = base + span;
        case ($urandom_range(0, 9))
            0: w.query_time = base - $urandom_range(0, 50);
            1: w.query_time = base + span + $urandom_range(0, 50);
            2: w.query_time = $urandom;
            default: w.query_time = base + (span == 0 ? 0 : $urandom % span);
        endcase
        return w;
    endfunction

    task automatic send_word(chi_pkg::t_in_word w);
        i_data <= w;
        i_valid <= 1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_input(w);
        @(negedge i_clk);
    endtask

    task automatic drop_valid();
        i_valid <= 0;
    endtask

    task automatic send_dir(logic [31:0] tq, logic [31:0] ts, logic [31:0] te,
                            logic [31:0] ya, logic [31:0] dya, logic [31:0] yb,
                            logic [31:0] dyb, logic last);
        chi_pkg::t_in_word w;
        w = {tq, ts, te, ya, dya, yb, dyb, last};
        send_word(w);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) board.check_result(o_data);
    end

    always @(negedge i_clk) begin
        case (stall_mode)
            0: i_ready <= 1;
            1: i_ready <= ($urandom_range(0, 3) != 0);
            default: i_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
    end

    initial begin
        int burst;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        send_dir(0, 0, 0, 32'h7fff_ffff, 0, 0, 0, 1);
        send_dir(5, 10, 5, 1, 1, 1, 1, 0);
        send_dir(0, 10, 110, 32'h0001_0000, 32'h100, 32'h0002_0000, 32'h200, 0);
        send_dir(500, 10, 110, 32'h0001_0000, 32'h100, 32'h0002_0000, 32'h200, 1);
        send_dir(60, 10, 110, 32'h0001_0000, 32'h100, 32'h0002_0000, 32'h200, 0);
        send_dir(32'h7fff_ffff, 0, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h8000_0000, 32'h8000_0000, 1);
        send_dir(32'h4000_0000, 0, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000,
                 32'h7fff_ffff, 32'h7fff_ffff, 0);
        send_dir(1, 0, 2, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h1, 1);
        send_dir(32'hffff_ffff, 32'hffff_fffe, 32'hffff_ffff, 0, 0, 0, 0, 0);
        send_dir(3, 0, 7, 32'hffff_ffff, 32'h7fff_ffff, 32'h0, 32'h8000_0000, 1);
        send_dir(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 5, 5, 5, 5, 1);
        send_dir(50, 0, 100, 32'h7fff_ffff, 0, 32'h8000_0000, 0, 0);
        drop_valid();
        while (board.pending.size() != 0) @(negedge i_clk);
        for (int n = 0; n < 1600; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < 1600; k++, n++) send_word(rand_word());
            if ($urandom_range(0, 2) != 0) begin
                drop_valid();
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
        drop_valid();
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: errors");
        $finish;
    end
endmodule
